[rtl/stq_pkg.sv]
// Shared types and constants for the sorted timer queue.
`default_nettype none
package stq_pkg;
   localparam logic [15:0] ANON_TAG = 16'hFFFF;
   localparam logic [31:0] MAX_INTERVAL_RESET = 32'h7FFF_FFFF;
   localparam logic REQ_SCHEDULE = 1'b0;
   localparam logic REQ_CHECK = 1'b1;
   // Handle bits kept per entry; the handle field on the ports is 8 bits
   localparam int HANDLE_BITS = 8;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FIND,
      ST_DEL,
      ST_DROP,
      ST_SCAN,
      ST_SHIFT,
      ST_PUT,
      ST_CHK,
      ST_FIRE,
      ST_POP,
      ST_RESP
   } state_type;

   // Memory access command from the sequencer to the entry store
   typedef struct packed {
      logic        rd;
      logic        wr;
      logic [7:0]  rd_addr;
      logic [7:0]  wr_addr;
   } mem_cmd_type;
endpackage
`default_nettype wire

[rtl/stq_store.sv]
// Entry store: due time, tag and handle memory with a registered read port.
`default_nettype none
module stq_store #(
   parameter int AW = 4,
   parameter int HB = 8
) (
   input  wire logic                    clock,
   input  wire logic                    rd,
   input  wire logic [AW-1:0]           rd_addr,
   input  wire logic                    wr,
   input  wire logic [AW-1:0]           wr_addr,
   input  wire logic [32+16+HB-1:0]     wr_data,
   output logic      [32+16+HB-1:0]     rd_data
);
   logic [32+16+HB-1:0] mem [2**AW];

   // Write port
   always_ff @(posedge clock) begin
      if (wr) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule
`default_nettype wire

[rtl/sorted_timer_queue_core.sv]
// Sorted timer queue: top level with sequencer around the entry store.
// Schedule: the tag search, the delete shift, the insert scan and the insert shift run in
// that order before the response. Check: a single response when nothing is due; each
// fired entry gives a response and is popped, moving the entries behind it down.
// One request at a time, taken once the last response loads.
// Reset (synchronous, active high) empties the queue and loads max_interval with 0x7FFFFFFF.
`default_nettype none
module sorted_timer_queue_core #(
   parameter int DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // req_tdata: now_ms[31:0], delay_ms[63:32], tag[79:64], handle[87:80]
   input  wire logic [87:0] req_tdata,
   // req_tuser: req_type
   input  wire logic        req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // rsp_tdata: accepted[0], fired[1], fired_tag[17:2], fired_handle[25:18], pad
   output logic [31:0]      rsp_tdata,
   output logic             rsp_tlast,
   input  wire logic        csr_we,
   input  wire logic [31:0] csr_wdata
);
   localparam int AW = (DEPTH <= 2) ? 1 : $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int HB = stq_pkg::HANDLE_BITS;
   localparam int DW = 32 + 16 + HB;

   stq_pkg::state_type state_ff, state_in;
   logic [31:0] maxi_ff;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] end_ff, end_in;
   logic [31:0] now_ff, delay_ff;
   logic [15:0] tag_ff;
   logic [HB-1:0] hnd_ff;
   logic req_ch_ff;
   logic [15:0] fire_tag_ff;
   logic [HB-1:0] fire_hnd_ff;
   logic fire_last_ff;
   logic acc_ff, acc_in;
   logic [DW-1:0] rd_data;
   logic [DW-1:0] wr_data;
   stq_pkg::mem_cmd_type cmd;
   logic req_fire;
   logic rsp_free;
   logic [31:0] due_rd, rel, age;
   logic [15:0] tag_rd;
   logic [HB-1:0] hnd_rd;
   logic stop_scan, is_due;
   logic [31:0] rsp_data_in;
   logic rsp_last_in;
   logic rsp_load;

   assign due_rd = rd_data[31:0];
   assign tag_rd = rd_data[47:32];
   assign hnd_rd = rd_data[DW-1:48];
   assign rel = due_rd - now_ff;
   assign age = now_ff - due_rd;
   assign stop_scan = (rel >= delay_ff) && (rel <= maxi_ff);
   assign is_due = age <= maxi_ff;
   assign rsp_free = !rsp_tvalid || rsp_tready;
   assign req_tready = (state_ff == stq_pkg::ST_IDLE);
   assign req_fire = req_tvalid && req_tready;

   stq_store #(.AW(AW), .HB(HB)) u_store (
      .clock   (clock),
      .rd      (cmd.rd),
      .rd_addr (cmd.rd_addr[AW-1:0]),
      .wr      (cmd.wr),
      .wr_addr (cmd.wr_addr[AW-1:0]),
      .wr_data (wr_data),
      .rd_data (rd_data)
   );

   // Next state and counters
   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      end_in = end_ff;
      acc_in = acc_ff;
      case (state_ff)
         stq_pkg::ST_IDLE: begin
            if (req_fire) begin
               idx_in = '0;
               acc_in = 1'b1;
               if (req_tuser == stq_pkg::REQ_CHECK) begin
                  state_in = (cnt_ff == '0) ? stq_pkg::ST_RESP : stq_pkg::ST_CHK;
               end else if (req_tdata[79:64] == stq_pkg::ANON_TAG || cnt_ff == '0) begin
                  state_in = stq_pkg::ST_DROP;
               end else begin
                  state_in = stq_pkg::ST_FIND;
               end
            end
         end
         // Read issued last cycle at idx; compare tag
         stq_pkg::ST_FIND: begin
            if (tag_rd == tag_ff) begin
               end_in = cnt_ff;
               state_in = stq_pkg::ST_DEL;
            end else if (idx_ff + 1'b1 >= cnt_ff) begin
               state_in = stq_pkg::ST_DROP;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         // Close the gap at idx: move entry idx+1 down each pass
         stq_pkg::ST_DEL: begin
            if (idx_ff + 1'b1 >= end_ff) begin
               cnt_in = cnt_ff - 1'b1;
               state_in = stq_pkg::ST_DROP;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         stq_pkg::ST_DROP: begin
            if (cnt_ff >= CW'(DEPTH)) begin
               acc_in = 1'b0;
               idx_in = '0;
               end_in = cnt_ff;
               state_in = stq_pkg::ST_DEL;
            end else begin
               idx_in = '0;
               state_in = (cnt_ff == '0) ? stq_pkg::ST_PUT : stq_pkg::ST_SCAN;
            end
         end
         stq_pkg::ST_SCAN: begin
            if (stop_scan) begin
               end_in = cnt_ff;
               state_in = stq_pkg::ST_SHIFT;
            end else if (idx_ff + 1'b1 >= cnt_ff) begin
               idx_in = cnt_ff;
               state_in = stq_pkg::ST_PUT;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         // Move entry end-1 up to end, working downward to idx
         stq_pkg::ST_SHIFT: begin
            if (end_ff - 1'b1 == idx_ff) begin
               state_in = stq_pkg::ST_PUT;
            end else begin
               end_in = end_ff - 1'b1;
            end
         end
         stq_pkg::ST_PUT: begin
            cnt_in = cnt_ff + 1'b1;
            state_in = stq_pkg::ST_RESP;
         end
         // Head entry is in rd_data; fire it or report nothing due
         stq_pkg::ST_CHK: begin
            state_in = is_due ? stq_pkg::ST_FIRE : stq_pkg::ST_RESP;
         end
         // Emit the held head once the response register is free; last comes from the entry behind it
         stq_pkg::ST_FIRE: begin
            if (rsp_free) begin
               idx_in = '0;
               end_in = cnt_ff;
               state_in = (cnt_ff == CW'(1)) ? stq_pkg::ST_IDLE : stq_pkg::ST_POP;
               cnt_in = cnt_ff - 1'b1;
            end
         end
         stq_pkg::ST_POP: begin
            if (idx_ff + 1'b1 >= end_ff - 1'b1) begin
               idx_in = '0;
               state_in = fire_last_ff ? stq_pkg::ST_IDLE : stq_pkg::ST_CHK;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         stq_pkg::ST_RESP: begin
            if (rsp_free) begin
               state_in = stq_pkg::ST_IDLE;
            end
         end
         default: state_in = stq_pkg::ST_IDLE;
      endcase
   end

   // Memory commands per state
   always_comb begin
      cmd = '0;
      wr_data = rd_data;
      case (state_ff)
         stq_pkg::ST_IDLE: begin
            cmd.rd = req_fire;
            cmd.rd_addr = '0;
         end
         stq_pkg::ST_FIND: begin
            cmd.rd = 1'b1;
            cmd.rd_addr = (tag_rd == tag_ff) ? 8'(idx_ff + 1'b1) : 8'(idx_ff + 1'b1);
         end
         stq_pkg::ST_DEL: begin
            cmd.wr = (idx_ff + 1'b1 < end_ff);
            cmd.wr_addr = 8'(idx_ff);
            cmd.rd = 1'b1;
            cmd.rd_addr = 8'(idx_ff + 2'd2);
         end
         stq_pkg::ST_DROP: begin
            cmd.rd = 1'b1;
            cmd.rd_addr = (cnt_ff >= CW'(DEPTH)) ? 8'd1 : 8'd0;
         end
         stq_pkg::ST_SCAN: begin
            cmd.rd = 1'b1;
            cmd.rd_addr = stop_scan ? 8'(cnt_ff - 1'b1) : 8'(idx_ff + 1'b1);
         end
         stq_pkg::ST_SHIFT: begin
            cmd.wr = 1'b1;
            cmd.wr_addr = 8'(end_ff);
            cmd.rd = 1'b1;
            cmd.rd_addr = 8'(end_ff - 2'd2);
         end
         stq_pkg::ST_PUT: begin
            cmd.wr = 1'b1;
            cmd.wr_addr = 8'(idx_ff);
            wr_data = {hnd_ff, tag_ff, now_ff + delay_ff};
         end
         // Fetch the entry behind the head; rd_data then holds while the response waits
         stq_pkg::ST_CHK: begin
            cmd.rd = (cnt_ff > CW'(1));
            cmd.rd_addr = 8'd1;
         end
         stq_pkg::ST_POP: begin
            cmd.wr = 1'b1;
            cmd.wr_addr = 8'(idx_ff);
            // On a single move rd_data already holds the new head, so skip the read
            cmd.rd = !((idx_ff + 1'b1 >= end_ff - 1'b1) && (idx_ff == '0));
            cmd.rd_addr = (idx_ff + 1'b1 >= end_ff - 1'b1) ? 8'd0 : 8'(idx_ff + 2'd2);
         end
         default: cmd = '0;
      endcase
   end

   // Response content
   always_comb begin
      rsp_load = 1'b0;
      rsp_data_in = '0;
      rsp_last_in = 1'b1;
      case (state_ff)
         stq_pkg::ST_FIRE: begin
            rsp_load = rsp_free;
            rsp_data_in[1] = 1'b1;
            rsp_data_in[17:2] = fire_tag_ff;
            rsp_data_in[18 +: HB] = fire_hnd_ff;
            rsp_last_in = !((cnt_ff > CW'(1)) && is_due);
         end
         stq_pkg::ST_RESP: begin
            rsp_load = rsp_free;
            rsp_data_in[0] = (req_ch_ff == stq_pkg::REQ_SCHEDULE) && acc_ff;
         end
         default: rsp_load = 1'b0;
      endcase
   end

   // Capture the request, the head entry being fired and its last flag
   always_ff @(posedge clock) begin
      if (req_fire) begin
         now_ff <= req_tdata[31:0];
         delay_ff <= req_tdata[63:32];
         tag_ff <= req_tdata[79:64];
         hnd_ff <= req_tdata[80 +: HB];
         req_ch_ff <= req_tuser;
      end
      if (state_ff == stq_pkg::ST_CHK) begin
         fire_tag_ff <= tag_rd;
         fire_hnd_ff <= hnd_rd;
      end
      if (state_ff == stq_pkg::ST_FIRE && rsp_free) begin
         fire_last_ff <= rsp_last_in;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= stq_pkg::ST_IDLE;
         cnt_ff <= '0;
         idx_ff <= '0;
         end_ff <= '0;
         acc_ff <= 1'b1;
         maxi_ff <= stq_pkg::MAX_INTERVAL_RESET;
         rsp_tvalid <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
         end_ff <= end_in;
         acc_ff <= acc_in;
         if (csr_we) begin
            maxi_ff <= csr_wdata;
         end
         if (rsp_load) begin
            rsp_tvalid <= 1'b1;
         end else if (rsp_tready) begin
            rsp_tvalid <= 1'b0;
         end
      end
   end

   // Response register
   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_tdata <= rsp_data_in;
         rsp_tlast <= rsp_last_in;
      end
   end
endmodule
`default_nettype wire

[rtl/stq_checker.sv]
// Port-level checker for the sorted timer queue, bound to the top level.
`default_nettype none
module stq_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata,
   input wire logic        rsp_tlast
);
   // A stalled response holds its payload
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("response changed while stalled");

   // A response never reports both accepted and fired
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[1]))
      else $error("accepted and fired together");

   // A non-fired response always ends its run
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[1] |-> rsp_tlast)
      else $error("plain response without last");

   // No response is pending right out of reset
   a_rst: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid out of reset");

   // A taken request closes the input for the next cycle
   a_take: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request input open right after a request");
endmodule

bind sorted_timer_queue_core stq_checker u_stq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
`default_nettype wire
